[design/ecefgeo_pkg.sv]
package ecefgeo_pkg;

  // Field widths
  localparam int PosW     = 35;
  localparam int FracBits = 16;
  localparam int QW       = PosW + FracBits;
  localparam int AxisW    = 33;
  localparam int E2W      = 32;
  localparam int TolW     = 16;
  localparam int IterW    = 5;
  localparam int AngOutW  = 32;
  localparam int MaxIter  = 16;

  // Internal datapath widths
  localparam int CordW     = 60;
  localparam int AngW      = 34;
  localparam int CordSteps = 30;
  localparam int StepW     = 5;
  localparam int DzW       = 57;
  localparam int MagW      = 57;
  localparam int PW        = 52;
  localparam int SinW      = 31;
  localparam int NW        = 54;

  // Request queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [E2W-1:0]         InvGain     = 32'd2608131496;
  localparam logic signed [AngW-1:0] QuarterTurn = 34'sd1073741824;

  // Configuration register indexes
  localparam logic [1:0] CfgAxis = 2'd0;
  localparam logic [1:0] CfgEcc  = 2'd1;
  localparam logic [1:0] CfgTol  = 2'd2;
  localparam logic [1:0] CfgIter = 2'd3;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic [PosW-1:0]      z_abs;
    logic                 z_neg;
    logic [IterW-1:0]     limit;
  } job_t;

  typedef struct packed {
    logic [AxisW-1:0] axis;
    logic [E2W-1:0]   e2;
    logic [TolW-1:0]  tol;
    logic [IterW-1:0] iter;
  } cfg_t;

  typedef struct packed {
    logic                    go;
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
  } cord_req_t;

  typedef struct packed {
    logic                    done;
    logic                    zero;
    logic signed [AngW-1:0]  ang;
    logic signed [CordW-1:0] x;
  } cord_rsp_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [AngW-1:0] atan_turn(input logic [StepW-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return signed'(AngW'(v));
  endfunction

endpackage

[design/ecefgeo_front.sv]
module ecefgeo_front (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_push,
  output logic                                     in_full,
  input  logic signed [ecefgeo_pkg::PosW-1:0]      in_pos_x,
  input  logic signed [ecefgeo_pkg::PosW-1:0]      in_pos_y,
  input  logic signed [ecefgeo_pkg::PosW-1:0]      in_pos_z,
  input  logic [ecefgeo_pkg::IterW-1:0]            max_iter,
  output logic                                     q_push,
  input  logic                                     q_full,
  output ecefgeo_pkg::job_t                        q_job
);

  logic              valid_r;
  ecefgeo_pkg::job_t job_r;
  ecefgeo_pkg::job_t job_nxt;
  logic              take;

  assign in_full = valid_r && q_full;
  assign take    = in_push && !in_full;
  assign q_push  = valid_r;
  assign q_job   = job_r;

  // Scale to Q16, split z into sign and magnitude, clamp the iteration limit
  always_comb begin
    job_nxt.x     = {in_pos_x, {ecefgeo_pkg::FracBits{1'b0}}};
    job_nxt.y     = {in_pos_y, {ecefgeo_pkg::FracBits{1'b0}}};
    job_nxt.z     = {in_pos_z, {ecefgeo_pkg::FracBits{1'b0}}};
    job_nxt.z_neg = in_pos_z[ecefgeo_pkg::PosW-1];
    job_nxt.z_abs = job_nxt.z_neg ? ecefgeo_pkg::PosW'(-in_pos_z)
                                  : ecefgeo_pkg::PosW'(in_pos_z);
    if (max_iter == '0) begin
      job_nxt.limit = ecefgeo_pkg::IterW'(1);
    end else if (max_iter > ecefgeo_pkg::IterW'(ecefgeo_pkg::MaxIter)) begin
      job_nxt.limit = ecefgeo_pkg::IterW'(ecefgeo_pkg::MaxIter);
    end else begin
      job_nxt.limit = max_iter;
    end
  end

  // Hold one classified request until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (take) begin
        valid_r <= 1'b1;
      end else if (valid_r && !q_full) begin
        valid_r <= 1'b0;
      end
    end
    if (take) begin
      job_r <= job_nxt;
    end
  end

endmodule

[design/ecefgeo_fifo.sv]
module ecefgeo_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  ecefgeo_pkg::job_t push_job,
  input  logic              pop,
  output logic              valid,
  output ecefgeo_pkg::job_t pop_job
);

  ecefgeo_pkg::job_t                 mem_r [ecefgeo_pkg::QDepth];
  logic [ecefgeo_pkg::QPtrW-1:0]     wr_r;
  logic [ecefgeo_pkg::QPtrW-1:0]     rd_r;
  logic [ecefgeo_pkg::QPtrW:0]       cnt_r;
  logic                              wr_en;
  logic                              rd_en;

  assign full    = cnt_r == (ecefgeo_pkg::QPtrW + 1)'(ecefgeo_pkg::QDepth);
  assign valid   = cnt_r != '0;
  assign pop_job = mem_r[rd_r];
  assign wr_en   = push && !full;
  assign rd_en   = pop && valid;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wr_r <= wr_r + 1'b1;
      end
      if (rd_en) begin
        rd_r <= rd_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (wr_en) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

[design/ecefgeo_cordic.sv]
module ecefgeo_cordic (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ecefgeo_pkg::cord_req_t req,
  output ecefgeo_pkg::cord_rsp_t rsp
);

  typedef enum logic {C_IDLE, C_RUN} cst_t;

  cst_t                                   st_r;
  logic                                   done_r;
  logic                                   zero_r;
  logic signed [ecefgeo_pkg::CordW-1:0]   x_r;
  logic signed [ecefgeo_pkg::CordW-1:0]   y_r;
  logic signed [ecefgeo_pkg::AngW-1:0]    a_r;
  logic [ecefgeo_pkg::StepW-1:0]          i_r;
  logic signed [ecefgeo_pkg::CordW-1:0]   dx;
  logic signed [ecefgeo_pkg::CordW-1:0]   dy;
  logic signed [ecefgeo_pkg::AngW-1:0]    da;

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign da = ecefgeo_pkg::atan_turn(i_r);

  assign rsp.done = done_r;
  assign rsp.zero = zero_r;
  assign rsp.ang  = a_r;
  assign rsp.x    = x_r;

  // Pre-rotate into the right half plane, then one micro-rotation a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        C_IDLE: begin
          if (req.go) begin
            if (req.x == '0 && req.y == '0) begin
              zero_r <= 1'b1;
              x_r    <= '0;
              a_r    <= '0;
              done_r <= 1'b1;
            end else begin
              zero_r <= 1'b0;
              i_r    <= '0;
              st_r   <= C_RUN;
              if (req.x[ecefgeo_pkg::CordW-1] && !req.y[ecefgeo_pkg::CordW-1]) begin
                x_r <= req.y;
                y_r <= -req.x;
                a_r <= ecefgeo_pkg::QuarterTurn;
              end else if (req.x[ecefgeo_pkg::CordW-1]) begin
                x_r <= -req.y;
                y_r <= req.x;
                a_r <= -ecefgeo_pkg::QuarterTurn;
              end else begin
                x_r <= req.x;
                y_r <= req.y;
                a_r <= '0;
              end
            end
          end
        end
        C_RUN: begin
          if (!y_r[ecefgeo_pkg::CordW-1]) begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            a_r <= a_r + da;
          end else begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            a_r <= a_r - da;
          end
          i_r <= i_r + 1'b1;
          if (i_r == ecefgeo_pkg::StepW'(ecefgeo_pkg::CordSteps - 1)) begin
            st_r   <= C_IDLE;
            done_r <= 1'b1;
          end
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

endmodule

[design/ecefgeo_back.sv]
module ecefgeo_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ecefgeo_pkg::cfg_t                      cfg,
  input  logic                                   q_valid,
  output logic                                   q_pop,
  input  ecefgeo_pkg::job_t                      q_job,
  output ecefgeo_pkg::cord_req_t                 cord_req,
  input  ecefgeo_pkg::cord_rsp_t                 cord_rsp,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [ecefgeo_pkg::AngOutW-1:0] out_longitude_angle,
  output logic signed [ecefgeo_pkg::AngOutW-1:0] out_latitude_angle,
  output logic signed [ecefgeo_pkg::PosW-1:0]    out_height_mm,
  output logic                                   out_converged,
  output logic [ecefgeo_pkg::IterW-1:0]          out_iterations_used
);

  localparam int OpW   = 64;
  localparam int HalfW = 32;
  localparam int AccW  = 2 * OpW;
  localparam int DvCntW = 7;
  localparam int HW    = ecefgeo_pkg::MagW + 2;
  localparam int SinPad = OpW - ecefgeo_pkg::DzW;
  localparam int AxPad  = OpW - ecefgeo_pkg::AxisW;
  localparam int SinFrac = 30;
  localparam int NFrac   = 46;

  localparam logic [OpW-1:0] OneQ60  = OpW'(1) << 60;
  localparam logic [OpW-1:0] OneQ30  = OpW'(1) << 30;
  localparam logic [OpW-1:0] NCap    = (OpW'(1) << 54) - OpW'(1);
  localparam logic [OpW-1:0] SqStart = OpW'(1) << 62;
  localparam logic [HW-1:0]  HalfLsb = HW'(32768);

  typedef enum logic [1:0] {SH_0, SH_16, SH_30, SH_32} msh_t;

  typedef enum logic [4:0] {
    B_IDLE, B_LON, B_LONG, B_DZ0, B_ITER, B_ITC, B_ITG, B_ITS, B_SS, B_T,
    B_Q, B_N, B_U, B_M, B_CHK, B_FC, B_FG, B_OUT
  } bst_t;

  bst_t st_r;

  // Per-item working registers
  ecefgeo_pkg::job_t                         job_r;
  logic [ecefgeo_pkg::AngOutW-1:0]           lon_r;
  logic [ecefgeo_pkg::AngOutW-1:0]           lat_r;
  logic [ecefgeo_pkg::PW-1:0]                p_r;
  logic signed [ecefgeo_pkg::DzW-1:0]        dz1_r;
  logic signed [ecefgeo_pkg::DzW-1:0]        dz2_r;
  logic signed [ecefgeo_pkg::DzW-1:0]        w_r;
  logic [ecefgeo_pkg::MagW-1:0]              r_r;
  logic [ecefgeo_pkg::SinW-1:0]              s_r;
  logic [ecefgeo_pkg::NW-1:0]                n_r;
  logic [ecefgeo_pkg::IterW-1:0]             cnt_r;
  logic                                      conv_r;
  logic                                      ov_r;

  // Unit requests
  logic                                      cord_go_r;
  logic signed [ecefgeo_pkg::CordW-1:0]      cord_x_r;
  logic signed [ecefgeo_pkg::CordW-1:0]      cord_y_r;
  logic                                      mul_go_r;
  logic [OpW-1:0]                            mul_a_r;
  logic [OpW-1:0]                            mul_b_r;
  msh_t                                      mul_sh_r;
  logic                                      dv_go_r;
  logic [OpW-1:0]                            dv_num_r;
  logic [OpW-1:0]                            dv_den_r;
  logic [OpW-1:0]                            dv_cap_r;
  logic [DvCntW-1:0]                         dv_steps_r;
  logic                                      sq_go_r;
  logic [OpW-1:0]                            sq_in_r;

  // Multiplier unit state
  logic [AccW-1:0]  mul_acc_r;
  logic [1:0]       mul_k_r;
  logic             mul_busy_r;
  logic             mul_done_r;
  logic [HalfW-1:0] mul_ach;
  logic [HalfW-1:0] mul_bch;
  logic [OpW-1:0]   mul_pp;
  logic [AccW-1:0]  mul_pps;
  logic [OpW-1:0]   mul_res;

  // Divider unit state
  logic [OpW-1:0]    dv_sh_r;
  logic [OpW-1:0]    dv_rem_r;
  logic [OpW-1:0]    dv_q_r;
  logic              dv_sat_r;
  logic [DvCntW-1:0] dv_cnt_r;
  logic              dv_busy_r;
  logic              dv_done_r;
  logic [OpW-1:0]    dv_rem2;
  logic              dv_ge;
  logic [OpW-1:0]    dv_qn;
  logic [OpW-1:0]    dv_res;

  // Square root unit state
  logic [OpW-1:0] sq_t_r;
  logic [OpW-1:0] sq_res_r;
  logic [OpW-1:0] sq_bit_r;
  logic           sq_busy_r;
  logic           sq_done_r;
  logic [OpW-1:0] sq_sum;
  logic           sq_ge;

  // Datapath helpers
  logic [OpW-1:0]                       cmag;
  logic signed [ecefgeo_pkg::DzW-1:0]   w_c;
  logic [ecefgeo_pkg::DzW-1:0]          w_abs;
  logic signed [ecefgeo_pkg::DzW-1:0]   m_s;
  logic signed [ecefgeo_pkg::DzW:0]     dd;
  logic [ecefgeo_pkg::DzW:0]            diff;
  logic signed [HW-1:0]                 hs;
  logic signed [HW-1:0]                 hq;
  logic signed [ecefgeo_pkg::PosW-1:0]  h_sat;

  assign q_pop = (st_r == B_IDLE) && q_valid;

  assign cord_req.go = cord_go_r;
  assign cord_req.x  = cord_x_r;
  assign cord_req.y  = cord_y_r;

  assign cmag  = cord_rsp.x[ecefgeo_pkg::CordW-1] ? '0 : OpW'(unsigned'(cord_rsp.x));
  assign w_c   = ecefgeo_pkg::DzW'(job_r.z) + dz1_r;
  assign w_abs = w_r[ecefgeo_pkg::DzW-1] ? unsigned'(-w_r) : unsigned'(w_r);
  assign m_s   = signed'(mul_res[ecefgeo_pkg::DzW-1:0]);
  assign dd    = (ecefgeo_pkg::DzW + 1)'(dz1_r) - (ecefgeo_pkg::DzW + 1)'(dz2_r);
  assign diff  = dd[ecefgeo_pkg::DzW] ? unsigned'(-dd) : unsigned'(dd);

  // Height: round half up from Q16, then saturate to the field
  assign hs = signed'(HW'(r_r)) - signed'(HW'(n_r)) + signed'(HalfLsb);
  assign hq = hs >>> ecefgeo_pkg::FracBits;
  always_comb begin
    if ((&hq[HW-1:ecefgeo_pkg::PosW-1]) || !(|hq[HW-1:ecefgeo_pkg::PosW-1])) begin
      h_sat = hq[ecefgeo_pkg::PosW-1:0];
    end else if (hq[HW-1]) begin
      h_sat = {1'b1, {(ecefgeo_pkg::PosW-1){1'b0}}};
    end else begin
      h_sat = {1'b0, {(ecefgeo_pkg::PosW-1){1'b1}}};
    end
  end

  assign out_empty = !ov_r;

  // Multiplier: four 32x32 partial products, one a cycle
  assign mul_ach = mul_k_r[1] ? mul_a_r[OpW-1:HalfW] : mul_a_r[HalfW-1:0];
  assign mul_bch = mul_k_r[0] ? mul_b_r[OpW-1:HalfW] : mul_b_r[HalfW-1:0];
  assign mul_pp  = OpW'(mul_ach) * OpW'(mul_bch);
  always_comb begin
    case (mul_k_r)
      2'd0:    mul_pps = {{OpW{1'b0}}, mul_pp};
      2'd3:    mul_pps = {mul_pp, {OpW{1'b0}}};
      default: mul_pps = {{HalfW{1'b0}}, mul_pp, {HalfW{1'b0}}};
    endcase
  end
  always_comb begin
    case (mul_sh_r)
      SH_0:    mul_res = mul_acc_r[OpW-1:0];
      SH_16:   mul_res = mul_acc_r[OpW+15:16];
      SH_30:   mul_res = mul_acc_r[OpW+29:30];
      SH_32:   mul_res = mul_acc_r[OpW+31:32];
      default: mul_res = mul_acc_r[OpW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
    end else begin
      mul_done_r <= 1'b0;
      if (mul_go_r) begin
        mul_busy_r <= 1'b1;
        mul_k_r    <= '0;
        mul_acc_r  <= '0;
      end else if (mul_busy_r) begin
        mul_acc_r <= mul_acc_r + mul_pps;
        mul_k_r   <= mul_k_r + 1'b1;
        if (mul_k_r == 2'd3) begin
          mul_busy_r <= 1'b0;
          mul_done_r <= 1'b1;
        end
      end
    end
  end

  // Divider: restoring, one quotient bit a cycle, saturating at the cap
  assign dv_rem2 = {dv_rem_r[OpW-2:0], dv_sh_r[OpW-1]};
  assign dv_ge   = dv_rem2 >= dv_den_r;
  assign dv_qn   = {dv_q_r[OpW-2:0], dv_ge};
  assign dv_res  = dv_sat_r ? dv_cap_r : dv_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
      dv_done_r <= 1'b0;
    end else begin
      dv_done_r <= 1'b0;
      if (dv_go_r) begin
        dv_busy_r <= 1'b1;
        dv_sh_r   <= dv_num_r;
        dv_rem_r  <= '0;
        dv_q_r    <= '0;
        dv_sat_r  <= 1'b0;
        dv_cnt_r  <= '0;
      end else if (dv_busy_r) begin
        dv_sh_r  <= {dv_sh_r[OpW-2:0], 1'b0};
        dv_rem_r <= dv_ge ? dv_rem2 - dv_den_r : dv_rem2;
        dv_q_r   <= dv_qn;
        dv_sat_r <= dv_sat_r || (dv_qn > dv_cap_r);
        dv_cnt_r <= dv_cnt_r + 1'b1;
        if (dv_cnt_r == dv_steps_r - 1'b1) begin
          dv_busy_r <= 1'b0;
          dv_done_r <= 1'b1;
        end
      end
    end
  end

  // Square root: one result bit a cycle
  assign sq_sum = sq_res_r + sq_bit_r;
  assign sq_ge  = sq_t_r >= sq_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      sq_done_r <= 1'b0;
    end else begin
      sq_done_r <= 1'b0;
      if (sq_go_r) begin
        sq_busy_r <= 1'b1;
        sq_t_r    <= sq_in_r;
        sq_res_r  <= '0;
        sq_bit_r  <= SqStart;
      end else if (sq_busy_r) begin
        sq_t_r   <= sq_ge ? sq_t_r - sq_sum : sq_t_r;
        sq_res_r <= sq_ge ? (sq_res_r >> 1) + sq_bit_r : sq_res_r >> 1;
        sq_bit_r <= sq_bit_r >> 2;
        if (sq_bit_r == OpW'(1)) begin
          sq_busy_r <= 1'b0;
          sq_done_r <= 1'b1;
        end
      end
    end
  end

  // Sequence one item: longitude, initial correction, refinement loop, latitude and height
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= B_IDLE;
      ov_r      <= 1'b0;
      cord_go_r <= 1'b0;
      mul_go_r  <= 1'b0;
      dv_go_r   <= 1'b0;
      sq_go_r   <= 1'b0;
    end else begin
      cord_go_r <= 1'b0;
      mul_go_r  <= 1'b0;
      dv_go_r   <= 1'b0;
      sq_go_r   <= 1'b0;
      if (out_pop && ov_r) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        B_IDLE: begin
          if (q_valid) begin
            job_r     <= q_job;
            cord_go_r <= 1'b1;
            cord_x_r  <= ecefgeo_pkg::CordW'(q_job.x);
            cord_y_r  <= ecefgeo_pkg::CordW'(q_job.y);
            st_r      <= B_LON;
          end
        end
        B_LON: begin
          if (cord_rsp.done) begin
            lon_r <= cord_rsp.ang[ecefgeo_pkg::AngOutW-1:0];
            mul_go_r <= 1'b1;
            if (cord_rsp.zero) begin
              p_r      <= '0;
              mul_a_r  <= OpW'(job_r.z_abs);
              mul_b_r  <= OpW'(cfg.e2);
              mul_sh_r <= SH_16;
              st_r     <= B_DZ0;
            end else begin
              mul_a_r  <= cmag;
              mul_b_r  <= OpW'(ecefgeo_pkg::InvGain);
              mul_sh_r <= SH_32;
              st_r     <= B_LONG;
            end
          end
        end
        B_LONG: begin
          if (mul_done_r) begin
            p_r      <= mul_res[ecefgeo_pkg::PW-1:0];
            mul_go_r <= 1'b1;
            mul_a_r  <= OpW'(job_r.z_abs);
            mul_b_r  <= OpW'(cfg.e2);
            mul_sh_r <= SH_16;
            st_r     <= B_DZ0;
          end
        end
        B_DZ0: begin
          if (mul_done_r) begin
            dz1_r <= job_r.z_neg ? -m_s : m_s;
            cnt_r <= '0;
            st_r  <= B_ITER;
          end
        end
        B_ITER: begin
          dz2_r     <= dz1_r;
          w_r       <= w_c;
          cord_go_r <= 1'b1;
          cord_x_r  <= ecefgeo_pkg::CordW'(p_r);
          cord_y_r  <= ecefgeo_pkg::CordW'(w_c);
          st_r      <= B_ITC;
        end
        B_ITC: begin
          if (cord_rsp.done) begin
            mul_go_r <= 1'b1;
            if (cord_rsp.zero) begin
              s_r      <= '0;
              mul_a_r  <= '0;
              mul_b_r  <= '0;
              mul_sh_r <= SH_0;
              st_r     <= B_SS;
            end else begin
              mul_a_r  <= cmag;
              mul_b_r  <= OpW'(ecefgeo_pkg::InvGain);
              mul_sh_r <= SH_32;
              st_r     <= B_ITG;
            end
          end
        end
        B_ITG: begin
          if (mul_done_r) begin
            if (mul_res == '0) begin
              s_r      <= '0;
              mul_go_r <= 1'b1;
              mul_a_r  <= '0;
              mul_b_r  <= '0;
              mul_sh_r <= SH_0;
              st_r     <= B_SS;
            end else begin
              dv_go_r    <= 1'b1;
              dv_num_r   <= {w_abs, {SinPad{1'b0}}};
              dv_den_r   <= mul_res;
              dv_cap_r   <= OneQ30;
              dv_steps_r <= DvCntW'(ecefgeo_pkg::DzW + SinFrac);
              st_r       <= B_ITS;
            end
          end
        end
        B_ITS: begin
          if (dv_done_r) begin
            s_r      <= dv_res[ecefgeo_pkg::SinW-1:0];
            mul_go_r <= 1'b1;
            mul_a_r  <= dv_res;
            mul_b_r  <= dv_res;
            mul_sh_r <= SH_0;
            st_r     <= B_SS;
          end
        end
        B_SS: begin
          if (mul_done_r) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= mul_res;
            mul_b_r  <= OpW'(cfg.e2);
            mul_sh_r <= SH_32;
            st_r     <= B_T;
          end
        end
        B_T: begin
          if (mul_done_r) begin
            sq_go_r <= 1'b1;
            sq_in_r <= OneQ60 - mul_res;
            st_r    <= B_Q;
          end
        end
        B_Q: begin
          if (sq_done_r) begin
            dv_go_r    <= 1'b1;
            dv_num_r   <= {cfg.axis, {AxPad{1'b0}}};
            dv_den_r   <= sq_res_r;
            dv_cap_r   <= NCap;
            dv_steps_r <= DvCntW'(ecefgeo_pkg::AxisW + NFrac);
            st_r       <= B_N;
          end
        end
        B_N: begin
          if (dv_done_r) begin
            n_r      <= dv_res[ecefgeo_pkg::NW-1:0];
            mul_go_r <= 1'b1;
            mul_a_r  <= dv_res;
            mul_b_r  <= OpW'(cfg.e2);
            mul_sh_r <= SH_32;
            st_r     <= B_U;
          end
        end
        B_U: begin
          if (mul_done_r) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= mul_res;
            mul_b_r  <= OpW'(s_r);
            mul_sh_r <= SH_30;
            st_r     <= B_M;
          end
        end
        B_M: begin
          if (mul_done_r) begin
            dz1_r <= w_r[ecefgeo_pkg::DzW-1] ? -m_s : m_s;
            cnt_r <= cnt_r + 1'b1;
            st_r  <= B_CHK;
          end
        end
        B_CHK: begin
          if (diff <= (ecefgeo_pkg::DzW + 1)'(cfg.tol) || cnt_r >= job_r.limit) begin
            conv_r    <= diff <= (ecefgeo_pkg::DzW + 1)'(cfg.tol);
            cord_go_r <= 1'b1;
            cord_x_r  <= ecefgeo_pkg::CordW'(p_r);
            cord_y_r  <= ecefgeo_pkg::CordW'(w_c);
            st_r      <= B_FC;
          end else begin
            st_r <= B_ITER;
          end
        end
        B_FC: begin
          if (cord_rsp.done) begin
            lat_r <= cord_rsp.ang[ecefgeo_pkg::AngOutW-1:0];
            if (cord_rsp.zero) begin
              r_r  <= '0;
              st_r <= B_OUT;
            end else begin
              mul_go_r <= 1'b1;
              mul_a_r  <= cmag;
              mul_b_r  <= OpW'(ecefgeo_pkg::InvGain);
              mul_sh_r <= SH_32;
              st_r     <= B_FG;
            end
          end
        end
        B_FG: begin
          if (mul_done_r) begin
            r_r  <= mul_res[ecefgeo_pkg::MagW-1:0];
            st_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (!ov_r || out_pop) begin
            ov_r                <= 1'b1;
            out_longitude_angle <= lon_r;
            out_latitude_angle  <= lat_r;
            out_height_mm       <= h_sat;
            out_converged       <= conv_r;
            out_iterations_used <= cnt_r;
            st_r                <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  // Only one arithmetic unit is ever running
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_busy_r && (dv_busy_r || sq_busy_r)) && !(dv_busy_r && sq_busy_r))
    else $error("two arithmetic units busy at once");

  // The refinement count stays within the item's limit
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_CHK) |-> (cnt_r != '0 && cnt_r <= job_r.limit))
    else $error("iteration count out of range");

  // A quotient only arrives where the sequencer waits for it
  a_div_sink: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done_r |-> (st_r == B_ITS || st_r == B_N))
    else $error("divider result not consumed");

  // A new request is taken only when the previous result has left the sequencer
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r == B_LON && !mul_busy_r && !dv_busy_r && !sq_busy_r))
    else $error("request taken while a unit was busy");

endmodule

[design/ecefgeo_top_dummy_never.sv]
module ecefgeo_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [ecefgeo_pkg::AxisW-1:0]      cfg_data,
  output ecefgeo_pkg::cfg_t                  cfg
);

  logic [ecefgeo_pkg::AxisW-1:0] axis_r;
  logic [ecefgeo_pkg::E2W-1:0]   e2_r;
  logic [ecefgeo_pkg::TolW-1:0]  tol_r;
  logic [ecefgeo_pkg::IterW-1:0] iter_r;

  assign cfg_ready = 1'b1;
  assign cfg.axis  = axis_r;
  assign cfg.e2    = e2_r;
  assign cfg.tol   = tol_r;
  assign cfg.iter  = iter_r;

  // Write one register per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= 33'd6378137000;
      e2_r   <= 32'd28752115;
      tol_r  <= 16'd1;
      iter_r <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ecefgeo_pkg::CfgAxis: axis_r <= cfg_data;
        ecefgeo_pkg::CfgEcc:  e2_r   <= cfg_data[ecefgeo_pkg::E2W-1:0];
        ecefgeo_pkg::CfgTol:  tol_r  <= cfg_data[ecefgeo_pkg::TolW-1:0];
        ecefgeo_pkg::CfgIter: iter_r <= cfg_data[ecefgeo_pkg::IterW-1:0];
        default: ;
      endcase
    end
  end

endmodule

[design/ecef_to_geodetic_iterative.sv]
// Converts an Earth-centred Cartesian position (mm) to longitude, latitude
// (signed fractions of a half turn) and ellipsoidal height (mm), by a
// fixed-point iteration on the z correction. Requests are pushed into a
// two-deep queue and results are popped from a one-entry output register.
// A request runs 1 to max_iterations latitude iterations (at most 16); the
// bit-serial divider (87 and 79 steps per iteration), the 30-step CORDIC
// and the 32-step square root set its duration. Requests are handled one
// at a time. Write configuration registers only while no request is in flight.
module ecef_to_geodetic_iterative (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic signed [ecefgeo_pkg::PosW-1:0]    in_pos_x,
  input  logic signed [ecefgeo_pkg::PosW-1:0]    in_pos_y,
  input  logic signed [ecefgeo_pkg::PosW-1:0]    in_pos_z,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [ecefgeo_pkg::AngOutW-1:0] out_longitude_angle,
  output logic signed [ecefgeo_pkg::AngOutW-1:0] out_latitude_angle,
  output logic signed [ecefgeo_pkg::PosW-1:0]    out_height_mm,
  output logic                                   out_converged,
  output logic [ecefgeo_pkg::IterW-1:0]          out_iterations_used,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [1:0]                             cfg_index,
  input  logic [ecefgeo_pkg::AxisW-1:0]          cfg_data
);

  ecefgeo_pkg::cfg_t      cfg;
  ecefgeo_pkg::job_t      f_job;
  ecefgeo_pkg::job_t      b_job;
  ecefgeo_pkg::cord_req_t cord_req;
  ecefgeo_pkg::cord_rsp_t cord_rsp;
  logic                   f_push;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;

  ecefgeo_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ecefgeo_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_pos_x (in_pos_x),
    .in_pos_y (in_pos_y),
    .in_pos_z (in_pos_z),
    .max_iter (cfg.iter),
    .q_push   (f_push),
    .q_full   (q_full),
    .q_job    (f_job)
  );

  ecefgeo_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .full     (q_full),
    .push_job (f_job),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (b_job)
  );

  ecefgeo_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cord_req),
    .rsp   (cord_rsp)
  );

  ecefgeo_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .q_valid             (q_valid),
    .q_pop               (q_pop),
    .q_job               (b_job),
    .cord_req            (cord_req),
    .cord_rsp            (cord_rsp),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_longitude_angle (out_longitude_angle),
    .out_latitude_angle  (out_latitude_angle),
    .out_height_mm       (out_height_mm),
    .out_converged       (out_converged),
    .out_iterations_used (out_iterations_used)
  );

endmodule
